@@ rtl/bsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and codes of the byte stack machine: commands, opcodes,
// fault codes, controller states and the multiply/divide control group.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int CMD_W       = 2;
    localparam int LADDR_W     = 10;
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 9;
    localparam int FAULT_W     = 3;
    localparam int PC_OUT_W    = 10;
    localparam int TOP_W       = 32;
    localparam int CFG_W       = 11;
    localparam int CFG_RESET   = 1024;

    localparam logic [7:0] BYTE_MASK    = 8'd255;
    localparam logic [7:0] OPCODE_COUNT = 8'd31;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        FLT_NONE   = 3'd0,
        FLT_STACK  = 3'd1,
        FLT_DIV0   = 3'd2,
        FLT_OPCODE = 3'd3,
        FLT_ADDR   = 3'd4
    } t_fault;

    localparam logic [7:0] OP_NOOP   = 8'd0;
    localparam logic [7:0] OP_ADD    = 8'd1;
    localparam logic [7:0] OP_SUB    = 8'd2;
    localparam logic [7:0] OP_MUL    = 8'd3;
    localparam logic [7:0] OP_DIV    = 8'd4;
    localparam logic [7:0] OP_MOD    = 8'd5;
    localparam logic [7:0] OP_DROP   = 8'd6;
    localparam logic [7:0] OP_SWAP   = 8'd7;
    localparam logic [7:0] OP_NIP    = 8'd8;
    localparam logic [7:0] OP_DUP    = 8'd9;
    localparam logic [7:0] OP_CFETCH = 8'd10;
    localparam logic [7:0] OP_FETCH  = 8'd11;
    localparam logic [7:0] OP_CSTORE = 8'd12;
    localparam logic [7:0] OP_STORE  = 8'd13;
    localparam logic [7:0] OP_GIVE   = 8'd14;
    localparam logic [7:0] OP_TAKE   = 8'd15;
    localparam logic [7:0] OP_LITC   = 8'd16;
    localparam logic [7:0] OP_LIT    = 8'd17;
    localparam logic [7:0] OP_EQU    = 8'd18;
    localparam logic [7:0] OP_LT     = 8'd19;
    localparam logic [7:0] OP_GT     = 8'd20;
    localparam logic [7:0] OP_NEG    = 8'd21;
    localparam logic [7:0] OP_AND    = 8'd22;
    localparam logic [7:0] OP_OR     = 8'd23;
    localparam logic [7:0] OP_XOR    = 8'd24;
    localparam logic [7:0] OP_BRANCH = 8'd25;
    localparam logic [7:0] OP_MAYBE  = 8'd26;
    localparam logic [7:0] OP_HALT   = 8'd27;
    localparam logic [7:0] OP_TOR    = 8'd28;
    localparam logic [7:0] OP_FROMR  = 8'd29;
    localparam logic [7:0] OP_MSWAP  = 8'd30;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_CFETCH,
        S_SWAP1,
        S_SWAP2,
        S_SWAP3,
        S_MULDIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_DIV = 2'd1,
        MD_MOD = 2'd2
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_ctl;

endpackage
`default_nettype wire

@@ rtl/bsm_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_if
// Channel interfaces of the byte stack machine: command requests, result
// requests and the configuration write channel.
// ----------------------------------------------------------------------------
interface bsm_in_if;
    import bsm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [LADDR_W-1:0]         load_addr;
    logic signed [BYTE_W-1:0]   load_data;
    logic signed [CHAR_W-1:0]   in_char;

    modport source (output valid, cmd, load_addr, load_data, in_char, input ready);
    modport sink   (input valid, cmd, load_addr, load_data, in_char, output ready);
endinterface

interface bsm_out_if;
    import bsm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       out_valid;
    logic [BYTE_W-1:0]          out_char;
    logic                       input_used;
    logic                       is_halted;
    logic [FAULT_W-1:0]         fault_code;
    logic [PC_OUT_W-1:0]        pc_now;
    logic signed [TOP_W-1:0]    top_value;

    modport source (output valid, out_valid, out_char, input_used, is_halted,
                    fault_code, pc_now, top_value, input ready);
    modport sink   (input valid, out_valid, out_char, input_used, is_halted,
                    fault_code, pc_now, top_value, output ready);
endinterface

interface bsm_cfg_if;
    import bsm_pkg::*;
    logic               valid;
    logic               ready;
    logic [CFG_W-1:0]   mem_length;

    modport source (output valid, mem_length, input ready);
    modport sink   (input valid, mem_length, output ready);
endinterface
`default_nettype wire

@@ rtl/bsm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module bsm_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/bsm_muldiv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_muldiv
// Iterative multiply and signed divide/modulo, one bit per cycle.
// Multiply keeps the low word; divide truncates toward zero, the remainder
// takes the sign of the dividend.
// ----------------------------------------------------------------------------
module bsm_muldiv #(
    parameter int WB = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsm_pkg::t_md_ctl  i_ctl,
    input  wire logic [WB-1:0]     i_a,
    input  wire logic [WB-1:0]     i_b,
    output logic                   o_done,
    output logic [WB-1:0]          o_result
);
    import bsm_pkg::*;

    localparam int CW = $clog2(WB + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    t_md_op        r_op, n_op;
    logic [WB:0]   r_acc, n_acc;
    logic [WB-1:0] r_shf, n_shf;
    logic [WB-1:0] r_opd, n_opd;
    logic          r_neg_q, n_neg_q;
    logic          r_neg_r, n_neg_r;

    logic [WB:0]   w_trial;
    logic [WB-1:0] w_quo, w_rem;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_acc   = r_acc;
        n_shf   = r_shf;
        n_opd   = r_opd;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        w_trial = {r_acc[WB-1:0], r_shf[WB-1]};
        if (i_ctl.start) begin
            n_busy  = 1'b1;
            n_cnt   = CW'(WB);
            n_op    = i_ctl.op;
            n_acc   = '0;
            n_neg_q = i_a[WB-1] ^ i_b[WB-1];
            n_neg_r = i_a[WB-1];
            if (i_ctl.op == MD_MUL) begin
                n_shf = i_b;
                n_opd = i_a;
            end else begin
                // work on magnitudes, fix signs at the end
                n_shf = i_a[WB-1] ? (~i_a + WB'(1)) : i_a;
                n_opd = i_b[WB-1] ? (~i_b + WB'(1)) : i_b;
            end
        end else if (r_busy) begin
            if (r_op == MD_MUL) begin
                if (r_shf[0]) begin
                    n_acc = {1'b0, r_acc[WB-1:0] + r_opd};
                end
                n_opd = {r_opd[WB-2:0], 1'b0};
                n_shf = {1'b0, r_shf[WB-1:1]};
            end else begin
                if (w_trial >= {1'b0, r_opd}) begin
                    n_acc = w_trial - {1'b0, r_opd};
                    n_shf = {r_shf[WB-2:0], 1'b1};
                end else begin
                    n_acc = w_trial;
                    n_shf = {r_shf[WB-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op    <= n_op;
        r_acc   <= n_acc;
        r_shf   <= n_shf;
        r_opd   <= n_opd;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
    end

    assign w_quo = r_neg_q ? (~r_shf + WB'(1)) : r_shf;
    assign w_rem = r_neg_r ? (~r_acc[WB-1:0] + WB'(1)) : r_acc[WB-1:0];

    always_comb begin
        case (r_op)
            MD_MUL:  o_result = r_acc[WB-1:0];
            MD_DIV:  o_result = w_quo;
            MD_MOD:  o_result = w_rem;
            default: o_result = r_acc[WB-1:0];
        endcase
    end

    assign o_done = r_done;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("muldiv started while busy");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("muldiv done while still busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("muldiv busy with zero count");
`endif
endmodule
`default_nettype wire

@@ rtl/byte_stack_machine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stack_machine_core
// Two-stack bytecode machine over a shared byte memory for code and data.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    cmd, load_addr, load_data, in_char
//  o_out    out  valid/ready    out_valid, out_char, input_used, is_halted,
//                               fault_code, pc_now, top_value
//  i_cfg    in   valid/ready    mem_length (always ready)
//
//  Load, restart and a step that halts at once go to the done state; a plain
//  step reads the byte and stack RAMs (registered reads), then executes;
//  cfetch adds a byte read, mswap a byte RAM port sequence, mul, div and mod
//  wait on the serial unit. One request is worked at a time; the next is
//  taken while a result waits in the output register. Reset is synchronous,
//  no clearing pass; a stalled output holds the controller in its done state.
// ----------------------------------------------------------------------------
module byte_stack_machine_core #(
    parameter int MEM_DEPTH    = 1024,
    parameter int PSTACK_DEPTH = 64,
    parameter int RSTACK_DEPTH = 128,
    parameter int WORD_BITS    = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bsm_in_if.sink     i_in,
    bsm_out_if.source  o_out,
    bsm_cfg_if.sink    i_cfg
);
    import bsm_pkg::*;

    localparam int WB   = WORD_BITS;
    localparam int AW   = $clog2(MEM_DEPTH);
    localparam int CLEN = $clog2(MEM_DEPTH + 1);
    localparam int LW   = (CLEN > CFG_W) ? CLEN : CFG_W;
    localparam int NW   = ((AW > 8) ? AW : 8) + 2;
    localparam int XW   = NW + LW;
    localparam int AXW  = WB + LW;
    localparam int PAW  = $clog2(PSTACK_DEPTH);
    localparam int PDW  = $clog2(PSTACK_DEPTH + 1);
    localparam int RAW  = $clog2(RSTACK_DEPTH);
    localparam int RDW  = $clog2(RSTACK_DEPTH + 1);
    localparam int LAXW = LADDR_W + CLEN + 1;

    // control and machine state
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_len;
    logic [AW-1:0]     r_pc, n_pc;
    logic              r_halt, n_halt;
    t_fault            r_fault, n_fault;
    logic [PDW-1:0]    r_pd, n_pd;
    logic [RDW-1:0]    r_rd, n_rd;
    logic              r_ovld, n_ovld;
    // datapath
    logic [WB-1:0]     r_tos, n_tos;
    logic [WB-1:0]     r_nos, n_nos;
    logic [WB-1:0]     r_third, n_third;
    logic [7:0]        r_op, n_op;
    logic [AW-1:0]     r_a1, n_a1;
    logic [AW-1:0]     r_a2, n_a2;
    logic [7:0]        r_d1, n_d1;
    logic [CHAR_W-1:0] r_in_char, n_in_char;
    logic              r_ov, n_ov;
    logic [7:0]        r_oc, n_oc;
    logic              r_iu, n_iu;
    // result register
    logic              r_o_ov;
    logic [7:0]        r_o_oc;
    logic              r_o_iu;
    logic              r_o_halt;
    logic [FAULT_W-1:0] r_o_fault;
    logic [PC_OUT_W-1:0] r_o_pc;
    logic [TOP_W-1:0]  r_o_top;

    // memory ports
    logic              bm_we;
    logic [AW-1:0]     bm_waddr, bm_raddr;
    logic [7:0]        bm_wdata, bm_rdata;
    logic              ps_we;
    logic [PAW-1:0]    ps_waddr, ps_raddr;
    logic [WB-1:0]     ps_wdata, ps_rdata;
    logic              rs_we;
    logic [RAW-1:0]    rs_waddr, rs_raddr;
    logic [WB-1:0]     rs_wdata, rs_rdata;

    t_md_ctl           md_ctl;
    logic              md_done;
    logic [WB-1:0]     md_result;

    // derived values
    logic              w_in_acc, w_out_load, w_load_ok, w_pc_ok, w_pc1_ge_len;
    logic              w_tos_ok, w_nos_ok, w_adv;
    logic [LW-1:0]     w_len;
    logic [PDW-1:0]    w_pd_m1, w_pd_m2, w_pd_m3, w_pd_p1;
    logic [RDW-1:0]    w_rd_m1;
    logic [NW-1:0]     w_pc_n, w_pc_p1, w_pc_p2, w_arg_n, w_npc;
    logic [AXW-1:0]    w_tos_w, w_nos_w;
    logic [WB+7:0]     w_byte_x;
    logic [WB+8:0]     w_char_x;
    logic [WB+31:0]    w_top_x;
    logic              w_need2, w_need1, w_push;
    t_fault            w_flt;

    bsm_ram #(.DEPTH(MEM_DEPTH), .WIDTH(8)) u_byte_ram (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(bm_raddr), .o_rdata(bm_rdata)
    );

    // parameter stack RAM holds the entries below the cached top
    bsm_ram #(.DEPTH(PSTACK_DEPTH), .WIDTH(WB)) u_pstack_ram (
        .i_clk(i_clk), .i_we(ps_we), .i_waddr(ps_waddr), .i_wdata(ps_wdata),
        .i_raddr(ps_raddr), .o_rdata(ps_rdata)
    );

    bsm_ram #(.DEPTH(RSTACK_DEPTH), .WIDTH(WB)) u_rstack_ram (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );

    bsm_muldiv #(.WB(WB)) u_muldiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(md_ctl),
        .i_a(r_nos), .i_b(r_tos), .o_done(md_done), .o_result(md_result)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_DONE) && (!r_ovld || o_out.ready);

    assign w_len = (LW'(r_len) < LW'(MEM_DEPTH)) ? LW'(r_len) : LW'(MEM_DEPTH);
    assign w_load_ok = LAXW'(i_in.load_addr) < LAXW'(MEM_DEPTH);
    assign w_pc_ok   = LW'(r_pc) < w_len;
    assign w_pc1_ge_len = (LW'(r_pc) + LW'(1)) >= w_len;

    assign w_pd_m1 = r_pd - PDW'(1);
    assign w_pd_m2 = r_pd - PDW'(2);
    assign w_pd_m3 = r_pd - PDW'(3);
    assign w_pd_p1 = r_pd + PDW'(1);
    assign w_rd_m1 = r_rd - RDW'(1);

    assign w_pc_n  = NW'(r_pc);
    assign w_pc_p1 = w_pc_n + NW'(1);
    assign w_pc_p2 = w_pc_n + NW'(2);
    assign w_arg_n = {{(NW-8){bm_rdata[7]}}, bm_rdata};

    assign w_tos_w  = AXW'(r_tos);
    assign w_nos_w  = AXW'(r_nos);
    assign w_tos_ok = !r_tos[WB-1] && (w_tos_w < AXW'(w_len));
    assign w_nos_ok = !r_nos[WB-1] && (w_nos_w < AXW'(w_len));
    assign w_byte_x = {{WB{bm_rdata[7]}}, bm_rdata};
    assign w_char_x = {{WB{r_in_char[CHAR_W-1]}}, r_in_char};
    assign w_top_x  = {{32{r_tos[WB-1]}}, r_tos};

    // stack demands and fault of the instruction in r_op
    always_comb begin
        w_need2 = 1'b0;
        w_need1 = 1'b0;
        w_push  = 1'b0;
        case (r_op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SWAP, OP_NIP, OP_CSTORE,
            OP_EQU, OP_LT, OP_GT, OP_AND, OP_OR, OP_XOR, OP_MSWAP: w_need2 = 1'b1;
            OP_DROP, OP_CFETCH, OP_GIVE, OP_NEG, OP_MAYBE, OP_TOR:  w_need1 = 1'b1;
            OP_DUP: begin
                w_need1 = 1'b1;
                w_push  = 1'b1;
            end
            OP_TAKE, OP_LITC, OP_FROMR: w_push = 1'b1;
            default: ;
        endcase

        if (r_op >= OPCODE_COUNT) begin
            w_flt = FLT_OPCODE;
        end else if ((w_need2 && (r_pd < PDW'(2))) || (w_need1 && (r_pd == '0)) ||
                     (w_push && (r_pd == PDW'(PSTACK_DEPTH))) ||
                     ((r_op == OP_TOR) && (r_rd == RDW'(RSTACK_DEPTH))) ||
                     ((r_op == OP_FROMR) && (r_rd == '0))) begin
            w_flt = FLT_STACK;
        end else if (((r_op == OP_DIV) || (r_op == OP_MOD)) && (r_tos == '0)) begin
            w_flt = FLT_DIV0;
        end else if (((r_op == OP_CFETCH) || (r_op == OP_CSTORE)) && !w_tos_ok) begin
            w_flt = FLT_ADDR;
        end else if (((r_op == OP_LITC) || (r_op == OP_BRANCH)) && w_pc1_ge_len) begin
            w_flt = FLT_ADDR;
        end else if ((r_op == OP_MSWAP) && !(w_nos_ok && w_tos_ok)) begin
            w_flt = FLT_ADDR;
        end else begin
            w_flt = FLT_NONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if ((t_cmd'(i_in.cmd) == CMD_STEP) && !r_halt && w_pc_ok) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                if (w_flt != FLT_NONE) begin
                    n_state = S_DONE;
                end else begin
                    case (r_op)
                        OP_MUL, OP_DIV, OP_MOD: n_state = S_MULDIV;
                        OP_CFETCH:              n_state = S_CFETCH;
                        OP_MSWAP:               n_state = S_SWAP1;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_CFETCH: n_state = S_DONE;
            S_SWAP1:  n_state = S_SWAP2;
            S_SWAP2:  n_state = S_SWAP3;
            S_SWAP3:  n_state = S_DONE;
            S_MULDIV: begin
                if (md_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_pc      = r_pc;
        n_halt    = r_halt;
        n_fault   = r_fault;
        n_pd      = r_pd;
        n_rd      = r_rd;
        n_tos     = r_tos;
        n_nos     = r_nos;
        n_third   = r_third;
        n_op      = r_op;
        n_a1      = r_a1;
        n_a2      = r_a2;
        n_d1      = r_d1;
        n_in_char = r_in_char;
        n_ov      = r_ov;
        n_oc      = r_oc;
        n_iu      = r_iu;
        bm_we     = 1'b0;
        bm_waddr  = r_a1;
        bm_wdata  = r_d1;
        bm_raddr  = r_pc;
        ps_we     = 1'b0;
        ps_waddr  = w_pd_m1[PAW-1:0];
        ps_wdata  = r_tos;
        ps_raddr  = w_pd_m2[PAW-1:0];
        rs_we     = 1'b0;
        rs_waddr  = r_rd[RAW-1:0];
        rs_wdata  = r_tos;
        rs_raddr  = w_rd_m1[RAW-1:0];
        md_ctl    = '{start: 1'b0, op: MD_MUL};
        w_adv     = 1'b0;
        w_npc     = w_pc_p1;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_in_char = i_in.in_char;
                    n_ov      = 1'b0;
                    n_oc      = '0;
                    n_iu      = 1'b0;
                    case (t_cmd'(i_in.cmd))
                        CMD_LOAD: begin
                            if (w_load_ok) begin
                                bm_we    = 1'b1;
                                bm_waddr = AW'(i_in.load_addr);
                                bm_wdata = i_in.load_data;
                            end
                        end
                        CMD_STEP: begin
                            if (!r_halt && !w_pc_ok) begin
                                n_halt = 1'b1;
                            end
                        end
                        CMD_RESTART: begin
                            n_pd    = '0;
                            n_rd    = '0;
                            n_pc    = '0;
                            n_halt  = 1'b0;
                            n_fault = FLT_NONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                n_op     = bm_rdata;
                n_nos    = ps_rdata;
                bm_raddr = w_pc_p1[AW-1:0];
                ps_raddr = w_pd_m3[PAW-1:0];
            end
            S_EXEC: begin
                // bm_rdata: byte after the opcode, ps_rdata: third entry
                n_third = ps_rdata;
                if (w_flt != FLT_NONE) begin
                    n_fault = w_flt;
                    n_halt  = 1'b1;
                end else begin
                    case (r_op)
                        OP_ADD: begin
                            n_tos = r_nos + r_tos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_SUB: begin
                            n_tos = r_nos - r_tos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_MUL: md_ctl = '{start: 1'b1, op: MD_MUL};
                        OP_DIV: md_ctl = '{start: 1'b1, op: MD_DIV};
                        OP_MOD: md_ctl = '{start: 1'b1, op: MD_MOD};
                        OP_EQU: begin
                            n_tos = WB'(r_nos == r_tos);
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_LT: begin
                            n_tos = WB'($signed(r_tos) < $signed(r_nos));
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_GT: begin
                            n_tos = WB'($signed(r_nos) < $signed(r_tos));
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_AND: begin
                            n_tos = r_nos & r_tos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_OR: begin
                            n_tos = r_nos | r_tos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_XOR: begin
                            n_tos = r_nos ^ r_tos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_DROP, OP_GIVE, OP_MAYBE: begin
                            n_tos = r_nos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                            if (r_op == OP_GIVE) begin
                                n_ov = 1'b1;
                                n_oc = r_tos[7:0] & BYTE_MASK;
                            end
                            if ((r_op == OP_MAYBE) && (r_tos == '0)) begin
                                w_npc = w_pc_p2;
                            end
                        end
                        OP_SWAP: begin
                            ps_we    = 1'b1;
                            ps_waddr = w_pd_m2[PAW-1:0];
                            n_tos    = r_nos;
                            w_adv    = 1'b1;
                        end
                        OP_NIP: begin
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_DUP: begin
                            ps_we = 1'b1;
                            n_pd  = w_pd_p1;
                            w_adv = 1'b1;
                        end
                        OP_CFETCH: bm_raddr = w_tos_w[AW-1:0];
                        OP_CSTORE: begin
                            bm_we    = 1'b1;
                            bm_waddr = w_tos_w[AW-1:0];
                            bm_wdata = r_nos[7:0];
                            n_tos    = ps_rdata;
                            n_pd     = w_pd_m2;
                            w_adv    = 1'b1;
                        end
                        OP_TAKE, OP_LITC, OP_FROMR: begin
                            // spill the old top below the new one
                            ps_we = (r_pd != '0);
                            n_pd  = w_pd_p1;
                            w_adv = 1'b1;
                            case (r_op)
                                OP_TAKE: begin
                                    n_tos = w_char_x[WB-1:0];
                                    n_iu  = 1'b1;
                                end
                                OP_LITC: begin
                                    n_tos = w_byte_x[WB-1:0];
                                    w_npc = w_pc_p2;
                                end
                                default: begin
                                    n_tos = rs_rdata;
                                    n_rd  = w_rd_m1;
                                end
                            endcase
                        end
                        OP_NEG: begin
                            n_tos = ~r_tos + WB'(1);
                            w_adv = 1'b1;
                        end
                        OP_BRANCH: begin
                            w_npc = w_pc_p1 + w_arg_n;
                            w_adv = 1'b1;
                        end
                        OP_HALT: begin
                            n_halt = 1'b1;
                            w_adv  = 1'b1;
                        end
                        OP_TOR: begin
                            rs_we = 1'b1;
                            n_rd  = r_rd + RDW'(1);
                            n_tos = r_nos;
                            n_pd  = w_pd_m1;
                            w_adv = 1'b1;
                        end
                        OP_MSWAP: begin
                            bm_raddr = w_nos_w[AW-1:0];
                            n_a1     = w_nos_w[AW-1:0];
                            n_a2     = w_tos_w[AW-1:0];
                        end
                        default: w_adv = 1'b1;
                    endcase
                end
            end
            S_CFETCH: begin
                n_tos = w_byte_x[WB-1:0];
                w_adv = 1'b1;
            end
            S_SWAP1: begin
                n_d1     = bm_rdata;
                bm_raddr = r_a2;
            end
            S_SWAP2: begin
                bm_we    = 1'b1;
                bm_waddr = r_a1;
                bm_wdata = bm_rdata;
            end
            S_SWAP3: begin
                bm_we    = 1'b1;
                bm_waddr = r_a2;
                bm_wdata = r_d1;
                n_tos    = r_third;
                n_pd     = w_pd_m2;
                w_adv    = 1'b1;
            end
            S_MULDIV: begin
                if (md_done) begin
                    n_tos = md_result;
                    n_pd  = w_pd_m1;
                    w_adv = 1'b1;
                end
            end
            default: ;
        endcase

        // running off either end halts and keeps the old pc
        if (w_adv) begin
            if (w_npc[NW-1] || !(XW'(w_npc) < XW'(w_len))) begin
                n_halt = 1'b1;
            end else begin
                n_pc = w_npc[AW-1:0];
            end
        end
    end

    always_comb begin
        n_ovld = r_ovld;
        if (w_out_load) begin
            n_ovld = 1'b1;
        end else if (o_out.ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= CFG_W'(CFG_RESET);
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_fault <= FLT_NONE;
            r_pd    <= '0;
            r_rd    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_fault <= n_fault;
            r_pd    <= n_pd;
            r_rd    <= n_rd;
            r_ovld  <= n_ovld;
            if (i_cfg.valid) begin
                r_len <= i_cfg.mem_length;
            end
        end
        r_tos     <= n_tos;
        r_nos     <= n_nos;
        r_third   <= n_third;
        r_op      <= n_op;
        r_a1      <= n_a1;
        r_a2      <= n_a2;
        r_d1      <= n_d1;
        r_in_char <= n_in_char;
        r_ov      <= n_ov;
        r_oc      <= n_oc;
        r_iu      <= n_iu;
        if (w_out_load) begin
            r_o_ov    <= r_ov;
            r_o_oc    <= r_oc;
            r_o_iu    <= r_iu;
            r_o_halt  <= r_halt;
            r_o_fault <= r_fault;
            r_o_pc    <= PC_OUT_W'(r_pc);
            r_o_top   <= (r_pd != '0) ? w_top_x[31:0] : '0;
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.out_valid  = r_o_ov;
    assign o_out.out_char   = r_o_oc;
    assign o_out.input_used = r_o_iu;
    assign o_out.is_halted  = r_o_halt;
    assign o_out.fault_code = r_o_fault;
    assign o_out.pc_now     = r_o_pc;
    assign o_out.top_value  = r_o_top;

`ifndef SYNTH
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != FLT_NONE) |-> r_halt)
        else $error("fault recorded without halt");
    a_pdepth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd <= PDW'(PSTACK_DEPTH))
        else $error("parameter stack depth beyond limit");
    a_rdepth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= RDW'(RSTACK_DEPTH))
        else $error("return stack depth beyond limit");
    a_md_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MULDIV) && md_done) |=> (r_state == S_DONE))
        else $error("muldiv result not taken");
    a_md_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_ctl.start |=> (r_state == S_MULDIV))
        else $error("muldiv started outside execute");
`endif
endmodule
`default_nettype wire
